[design/lpcp_pkg.sv]
package lpcp_pkg;

  localparam int ACC_W      = 35;
  localparam int QUO_W      = 16;
  localparam int DIV_W      = ACC_W + QUO_W;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;
  localparam int OUT_DATA_W = 120;

  localparam logic [3:0] MUL_STEPS = 4'd9;
  localparam logic [3:0] DIV_LAST  = 4'd15;

  localparam logic [CFG_IDX_W-1:0] REG_ROW0   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROW1   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROW2   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_GROUND = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_CAMERA = 3'd6;

  localparam logic [12:0]        IMG_W_RST  = 13'd640;
  localparam logic [12:0]        IMG_H_RST  = 13'd480;
  localparam logic signed [15:0] GROUND_RST = -16'sd77;

  typedef struct packed {
    logic                    mode;
    logic                    last;
    logic                    above;
    logic signed [ACC_W-1:0] bx;
    logic signed [ACC_W-1:0] by;
    logic signed [ACC_W-1:0] bz;
  } proj_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef enum logic [1:0] {FE_IDLE, FE_MUL, FE_PUSH} fe_state_t;
  typedef enum logic [2:0] {BK_IDLE, BK_ABS, BK_DIV, BK_FIX, BK_OUT} bk_state_t;

endpackage

[design/lpcp_front.sv]
module lpcp_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_mode,
  input  logic                        in_last,
  input  logic signed [15:0]          in_px,
  input  logic signed [15:0]          in_py,
  input  logic signed [15:0]          in_pz,
  input  logic [63:0]                 row0,
  input  logic [63:0]                 row1,
  input  logic [63:0]                 row2,
  input  logic signed [15:0]          ground_min_z,
  input  lpcp_pkg::q_stat_t           q_stat,
  output logic                        push,
  output lpcp_pkg::proj_item_t        push_item
);
  import lpcp_pkg::*;

  fe_state_t state_r, state_nxt;
  logic [3:0] cnt_r;
  logic [1:0] col_r, row_r, prod_row_r;
  logic prod_vld_r;
  logic signed [31:0] prod_r, prod_nxt;
  logic signed [ACC_W-1:0] acc_x_r, acc_y_r, acc_z_r;
  logic signed [15:0] px_r, py_r, pz_r, coef, pt_sel;
  logic [63:0] row_sel;
  logic mode_r, last_r, above_r;
  logic accept;

  assign accept = in_valid && in_ready;

  always_comb begin
    case (row_r)
      2'd0:    row_sel = row0;
      2'd1:    row_sel = row1;
      default: row_sel = row2;
    endcase
    case (col_r)
      2'd0: begin
        coef   = row_sel[15:0];
        pt_sel = px_r;
      end
      2'd1: begin
        coef   = row_sel[31:16];
        pt_sel = py_r;
      end
      default: begin
        coef   = row_sel[47:32];
        pt_sel = pz_r;
      end
    endcase
    prod_nxt = coef * pt_sel;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      FE_IDLE: if (accept) state_nxt = FE_MUL;
      FE_MUL:  if (cnt_r == MUL_STEPS) state_nxt = FE_PUSH;
      FE_PUSH: if (!q_stat.full) state_nxt = FE_IDLE;
      default: state_nxt = FE_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = (state_r == FE_IDLE);
    push      = (state_r == FE_PUSH) && !q_stat.full;
    push_item = '{mode: mode_r, last: last_r, above: above_r,
                  bx: acc_x_r, by: acc_y_r, bz: acc_z_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= FE_IDLE;
      cnt_r      <= '0;
      prod_vld_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (accept) begin
        cnt_r      <= '0;
        prod_vld_r <= 1'b0;
      end else if (state_r == FE_MUL) begin
        cnt_r      <= cnt_r + 4'd1;
        prod_vld_r <= (cnt_r < MUL_STEPS);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      px_r    <= in_px;
      py_r    <= in_py;
      pz_r    <= in_pz;
      mode_r  <= in_mode;
      last_r  <= in_last;
      above_r <= (in_pz > ground_min_z);
      col_r   <= '0;
      row_r   <= '0;
      acc_x_r <= {{(ACC_W-26){row0[63]}}, row0[63:48], 10'b0};
      acc_y_r <= {{(ACC_W-26){row1[63]}}, row1[63:48], 10'b0};
      acc_z_r <= {{(ACC_W-26){row2[63]}}, row2[63:48], 10'b0};
    end else if (state_r == FE_MUL) begin
      if (cnt_r < MUL_STEPS) begin
        prod_r     <= prod_nxt;
        prod_row_r <= row_r;
        if (col_r == 2'd2) begin
          col_r <= '0;
          row_r <= row_r + 2'd1;
        end else begin
          col_r <= col_r + 2'd1;
        end
      end
      if (prod_vld_r) begin
        case (prod_row_r)
          2'd0:    acc_x_r <= acc_x_r + ACC_W'(prod_r);
          2'd1:    acc_y_r <= acc_y_r + ACC_W'(prod_r);
          default: acc_z_r <= acc_z_r + ACC_W'(prod_r);
        endcase
      end
    end
  end

endmodule

[design/lpcp_queue.sv]
module lpcp_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  lpcp_pkg::proj_item_t push_item,
  input  logic                 pop,
  output lpcp_pkg::proj_item_t pop_item,
  output lpcp_pkg::q_stat_t    q_stat
);
  import lpcp_pkg::*;

  proj_item_t mem_r [2];
  logic wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r;

  assign pop_item     = mem_r[rd_ptr_r];
  assign q_stat.full  = (count_r == 2'd2);
  assign q_stat.empty = (count_r == 2'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (pop) rd_ptr_r <= !rd_ptr_r;
      if (push && !pop) count_r <= count_r + 2'd1;
      else if (pop && !push) count_r <= count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_item;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n) count_r <= 2'd2)
    else $error("queue count out of range");
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.full |-> !push)
    else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.empty |-> !pop)
    else $error("pop from empty queue");

endmodule

[design/lpcp_back.sv]
module lpcp_back #(
  parameter int COUNT_WIDTH = 12
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  lpcp_pkg::q_stat_t                   q_stat,
  output logic                                pop,
  input  lpcp_pkg::proj_item_t                pop_item,
  input  logic [12:0]                         image_width,
  input  logic [12:0]                         image_height,
  input  logic [7:0]                          camera_id,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [lpcp_pkg::OUT_DATA_W-1:0]     out_data,
  output logic                                out_box_valid
);
  import lpcp_pkg::*;

  bk_state_t state_r, state_nxt;
  proj_item_t ent_r;
  logic [ACC_W-1:0] rem_x_r, rem_y_r, dz_r;
  logic [DIV_W-1:0] div_r;
  logic [QUO_W-1:0] qx_r, qy_r;
  logic [3:0] cnt_r;
  logic signed [15:0] u_r, v_r;
  logic derr_r;
  logic signed [15:0] min_u_r, min_v_r, max_u_r, max_v_r;
  logic [COUNT_WIDTH-1:0] count_r;
  logic out_valid_r, out_box_r;
  logic [OUT_DATA_W-1:0] out_data_r;

  logic [ACC_W-1:0] abs_x, abs_y, abs_z;
  logic [DIV_W:0] diff_x, diff_y;
  logic signed [15:0] u_fix, v_fix, nmin_u, nmin_v, nmax_u, nmax_v;
  logic signed [16:0] wlim, hlim, box_w, box_h;
  logic [COUNT_WIDTH-1:0] ncount;
  logic [11:0] box_pts;
  logic in_view, fire;
  logic [OUT_DATA_W-1:0] data_nxt;

  function automatic logic signed [15:0] fix_pix(logic signed [ACC_W-1:0] num,
                                                 logic den_zero, logic den_neg,
                                                 logic sat, logic [QUO_W-1:0] q);
    logic neg;
    neg = num[ACC_W-1] ^ den_neg;
    if (den_zero) begin
      if (num[ACC_W-1]) fix_pix = -16'sd32768;
      else if (num != '0) fix_pix = 16'sd32767;
      else fix_pix = '0;
    end else if (neg) begin
      if (sat || q > 16'd32768) fix_pix = -16'sd32768;
      else fix_pix = 16'(-q);
    end else begin
      if (sat || q > 16'd32767) fix_pix = 16'sd32767;
      else fix_pix = q;
    end
  endfunction

  always_comb begin
    abs_x  = ent_r.bx[ACC_W-1] ? ACC_W'(-ent_r.bx) : ent_r.bx;
    abs_y  = ent_r.by[ACC_W-1] ? ACC_W'(-ent_r.by) : ent_r.by;
    abs_z  = ent_r.bz[ACC_W-1] ? ACC_W'(-ent_r.bz) : ent_r.bz;
    diff_x = {1'b0, DIV_W'(rem_x_r)} - {1'b0, div_r};
    diff_y = {1'b0, DIV_W'(rem_y_r)} - {1'b0, div_r};
    u_fix  = fix_pix(ent_r.bx, dz_r == '0, ent_r.bz[ACC_W-1], rem_x_r >= dz_r, qx_r);
    v_fix  = fix_pix(ent_r.by, dz_r == '0, ent_r.bz[ACC_W-1], rem_y_r >= dz_r, qy_r);
  end

  always_comb begin
    wlim    = 17'({4'b0, image_width}) - 17'sd1;
    hlim    = 17'({4'b0, image_height}) - 17'sd1;
    in_view = !ent_r.mode && ent_r.above && !ent_r.bz[ACC_W-1] && (ent_r.bz != '0) &&
              !ent_r.bx[ACC_W-1] && !ent_r.by[ACC_W-1] &&
              (17'(u_r) < wlim) && (17'(v_r) < hlim);
    nmin_u  = (min_u_r > u_r) ? u_r : min_u_r;
    nmin_v  = (min_v_r > v_r) ? v_r : min_v_r;
    nmax_u  = (max_u_r < u_r) ? u_r : max_u_r;
    nmax_v  = (max_v_r < v_r) ? v_r : max_v_r;
    ncount  = (count_r == {COUNT_WIDTH{1'b1}}) ? count_r : count_r + COUNT_WIDTH'(1);
    box_w   = 17'(nmax_u) - 17'(nmin_u);
    box_h   = 17'(nmax_v) - 17'(nmin_v);
    box_pts = (25'(ncount) > 25'd4095) ? 12'd4095 : 12'(ncount);
    data_nxt = '0;
    data_nxt[0]      = in_view;
    data_nxt[16:1]   = u_r;
    data_nxt[32:17]  = v_r;
    data_nxt[119]    = derr_r;
    if (ent_r.mode && ent_r.last) begin
      data_nxt[48:33]   = nmin_u;
      data_nxt[64:49]   = nmin_v;
      data_nxt[81:65]   = box_w;
      data_nxt[98:82]   = box_h;
      data_nxt[110:99]  = box_pts;
      data_nxt[118:111] = camera_id;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE: if (!q_stat.empty) state_nxt = BK_ABS;
      BK_ABS:  state_nxt = BK_DIV;
      BK_DIV:  if (cnt_r == DIV_LAST) state_nxt = BK_FIX;
      BK_FIX:  state_nxt = BK_OUT;
      BK_OUT:  if (fire) state_nxt = BK_IDLE;
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    pop           = (state_r == BK_IDLE) && !q_stat.empty;
    fire          = (state_r == BK_OUT) && (!out_valid_r || out_ready);
    out_valid     = out_valid_r;
    out_data      = out_data_r;
    out_box_valid = out_box_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      out_valid_r <= 1'b0;
      min_u_r     <= 16'({3'b0, IMG_W_RST});
      min_v_r     <= 16'({3'b0, IMG_H_RST});
      max_u_r     <= '0;
      max_v_r     <= '0;
      count_r     <= '0;
    end else begin
      state_r <= state_nxt;
      if (fire) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
      if (fire && ent_r.mode) begin
        if (ent_r.last) begin
          min_u_r <= 16'({3'b0, image_width});
          min_v_r <= 16'({3'b0, image_height});
          max_u_r <= '0;
          max_v_r <= '0;
          count_r <= '0;
        end else begin
          min_u_r <= nmin_u;
          min_v_r <= nmin_v;
          max_u_r <= nmax_u;
          max_v_r <= nmax_v;
          count_r <= ncount;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      BK_IDLE: if (pop) ent_r <= pop_item;
      BK_ABS: begin
        rem_x_r <= abs_x;
        rem_y_r <= abs_y;
        dz_r    <= abs_z;
        div_r   <= DIV_W'(abs_z) << (QUO_W - 1);
        qx_r    <= '0;
        qy_r    <= '0;
        cnt_r   <= '0;
      end
      BK_DIV: begin
        if (!diff_x[DIV_W]) begin
          rem_x_r <= ACC_W'(diff_x);
          qx_r    <= {qx_r[QUO_W-2:0], 1'b1};
        end else begin
          qx_r <= {qx_r[QUO_W-2:0], 1'b0};
        end
        if (!diff_y[DIV_W]) begin
          rem_y_r <= ACC_W'(diff_y);
          qy_r    <= {qy_r[QUO_W-2:0], 1'b1};
        end else begin
          qy_r <= {qy_r[QUO_W-2:0], 1'b0};
        end
        div_r <= div_r >> 1;
        cnt_r <= cnt_r + 4'd1;
      end
      BK_FIX: begin
        u_r    <= u_fix;
        v_r    <= v_fix;
        derr_r <= (dz_r == '0);
      end
      BK_OUT: if (fire) begin
        out_data_r <= data_nxt;
        out_box_r  <= ent_r.mode && ent_r.last;
      end
      default: ;
    endcase
  end

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |=> out_valid_r && $stable(out_data_r))
    else $error("result dropped while stalled");
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> state_r == BK_IDLE)
    else $error("pop outside idle");
  a_div_len: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == BK_FIX |-> $past(state_r) == BK_DIV && $past(cnt_r) == DIV_LAST)
    else $error("divider step count wrong");

endmodule

[design/lidar_point_camera_projection_box.sv]
// The 16-step shared divider (two quotients in parallel) in the back end takes
// one item at a time; the 9-product shared multiplier front end overlaps it
// through a two-entry queue.
// Reset (rst_n, synchronous, active low) restores the register defaults,
// empties the queue and output register, and clears the cluster box.
module lidar_point_camera_projection_box #(
  parameter int COUNT_WIDTH = 12
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [47:0]                           in_tdata,  // point_x, point_y, point_z
  input  logic                                  in_tuser,  // mode
  input  logic                                  in_tlast,  // last_of_cluster
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  // in_view, pixel_u, pixel_v, box_x, box_y, box_w, box_h, box_points,
  // box_camera, divide_error
  output logic [lpcp_pkg::OUT_DATA_W-1:0]       out_tdata,
  output logic                                  out_tuser, // box_valid
  input  logic                                  cfg_we,
  input  logic [lpcp_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [lpcp_pkg::CFG_DATA_W-1:0]       cfg_wdata
);
  import lpcp_pkg::*;

  logic [63:0] row0_r, row1_r, row2_r;
  logic [12:0] width_r, height_r;
  logic signed [15:0] ground_r;
  logic [7:0] camera_r;
  q_stat_t q_stat;
  logic push, pop;
  proj_item_t push_item, pop_item;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row0_r   <= '0;
      row1_r   <= '0;
      row2_r   <= '0;
      width_r  <= IMG_W_RST;
      height_r <= IMG_H_RST;
      ground_r <= GROUND_RST;
      camera_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ROW0:   row0_r   <= cfg_wdata;
        REG_ROW1:   row1_r   <= cfg_wdata;
        REG_ROW2:   row2_r   <= cfg_wdata;
        REG_WIDTH:  width_r  <= cfg_wdata[12:0];
        REG_HEIGHT: height_r <= cfg_wdata[12:0];
        REG_GROUND: ground_r <= cfg_wdata[15:0];
        REG_CAMERA: camera_r <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  lpcp_front u_front (
    .clk, .rst_n,
    .in_valid(in_tvalid), .in_ready(in_tready),
    .in_mode(in_tuser), .in_last(in_tlast),
    .in_px(in_tdata[15:0]), .in_py(in_tdata[31:16]), .in_pz(in_tdata[47:32]),
    .row0(row0_r), .row1(row1_r), .row2(row2_r), .ground_min_z(ground_r),
    .q_stat, .push, .push_item
  );

  lpcp_queue u_queue (
    .clk, .rst_n, .push, .push_item, .pop, .pop_item, .q_stat
  );

  lpcp_back #(.COUNT_WIDTH(COUNT_WIDTH)) u_back (
    .clk, .rst_n, .q_stat, .pop, .pop_item,
    .image_width(width_r), .image_height(height_r), .camera_id(camera_r),
    .out_valid(out_tvalid), .out_ready(out_tready),
    .out_data(out_tdata), .out_box_valid(out_tuser)
  );

endmodule
